// ----- hw/rtl/sfc_pkg.sv -----
// shared types and constants of the tcp syn frame classifier
`default_nettype none
package sfc_pkg;

	// one frame byte with its end-of-frame mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// one classification result
	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] source_address;
		logic [31:0] frames_seen;
	} out_item_t;

	// verdict codes
	localparam logic [1:0] VERDICT_PASS   = 2'd0;
	localparam logic [1:0] VERDICT_REFUSE = 2'd1;
	localparam logic [1:0] VERDICT_GATE   = 2'd2;

	// register reset value
	localparam logic [15:0] PORT_RESET = 16'd443;

	// byte offsets and lengths
	localparam logic [6:0] OFFSET_MAX   = 7'd127;
	localparam logic [6:0] OFS_ETYPE_HI = 7'd12;
	localparam logic [6:0] OFS_ETYPE_LO = 7'd13;
	localparam logic [6:0] OFS_VER_IHL  = 7'd14;
	localparam logic [6:0] OFS_FRAG_HI  = 7'd20;
	localparam logic [6:0] OFS_FRAG_LO  = 7'd21;
	localparam logic [6:0] OFS_PROTO    = 7'd23;
	localparam logic [6:0] OFS_SRC_LO   = 7'd26;
	localparam logic [6:0] OFS_SRC_HI   = 7'd29;
	localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
	localparam logic [6:0] TCP6_BASE    = 7'd54;
	localparam logic [6:0] TCP_PORT_HI  = 7'd2;
	localparam logic [6:0] TCP_PORT_LO  = 7'd3;
	localparam logic [6:0] TCP_FLAGS    = 7'd13;
	localparam logic [7:0] MIN_LEN_V6   = 8'd74;
	localparam logic [7:0] MIN_LEN_V4   = 8'd54;
	localparam logic [7:0] ETH_TCP_LEN  = 8'd34;
	localparam logic [5:0] IP4_MIN_LEN  = 6'd20;

	// header field values
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [3:0]  IP_VER4    = 4'd4;
	localparam logic [3:0]  IP_VER6    = 4'd6;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [15:0] FRAG_MASK  = 16'h3FFF;
	localparam int unsigned FLAG_SYN_BIT = 1;
	localparam int unsigned FLAG_ACK_BIT = 4;

endpackage
`default_nettype wire

// ----- hw/rtl/sfc_in_stage.sv -----
// input register stage of the tcp syn frame classifier
`default_nettype none
module sfc_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire sfc_pkg::in_item_t in_item,
	input  wire logic             out_free,
	output logic                  step,
	output sfc_pkg::in_item_t     item_s1
);
	import sfc_pkg::*;

	logic valid_s1;
	logic take;

	// a held byte moves on unless it closes a frame and the result slot holds a stalled result
	assign step     = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_stall = valid_s1 && !step;
	assign take     = in_valid && !in_stall;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sfc_hdr_capture.sv -----
// header field capture and verdict logic of the tcp syn frame classifier
`default_nettype none
module sfc_hdr_capture (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire sfc_pkg::in_item_t item_s1,
	input  wire logic [15:0]       port,
	output sfc_pkg::out_item_t     result
);
	import sfc_pkg::*;

	logic [6:0]  offset_q;
	logic [15:0] etype_q, etype_d;
	logic [7:0]  ver_ihl_q, ver_ihl_d;
	logic [15:0] frag_q, frag_d;
	logic [7:0]  proto_q, proto_d;
	logic [7:0]  v6_next_q, v6_next_d;
	logic [31:0] src_q, src_d;
	logic [15:0] v4_port_q, v4_port_d;
	logic [15:0] v6_port_q, v6_port_d;
	logic [7:0]  flags_q, flags_d;
	logic [31:0] count_q, count_d;

	logic [6:0]  pos;
	logic [7:0]  b;
	logic        cap;
	logic [6:0]  tcp4;
	logic [7:0]  len;
	logic [5:0]  ihl4;
	logic        v6_hit;
	logic        v4_hit;

	assign pos  = offset_q;
	assign b    = item_s1.data_byte;
	assign cap  = (pos != OFFSET_MAX);
	assign tcp4 = ETH_HDR_LEN + {1'b0, ver_ihl_q[3:0], 2'b00};

	// field values after this byte lands
	always_comb begin
		etype_d   = etype_q;
		ver_ihl_d = ver_ihl_q;
		frag_d    = frag_q;
		proto_d   = proto_q;
		v6_next_d = v6_next_q;
		src_d     = src_q;
		v4_port_d = v4_port_q;
		v6_port_d = v6_port_q;
		flags_d   = flags_q;
		if (cap) begin
			if (pos == OFS_ETYPE_HI) etype_d[15:8] = b;
			if (pos == OFS_ETYPE_LO) etype_d[7:0] = b;
			if (pos == OFS_VER_IHL) ver_ihl_d = b;
			if (pos == OFS_FRAG_HI) begin
				frag_d[15:8] = b;
				v6_next_d    = b;
			end
			if (pos == OFS_FRAG_LO) frag_d[7:0] = b;
			if (pos == OFS_PROTO) proto_d = b;
			if (pos >= OFS_SRC_LO && pos <= OFS_SRC_HI) src_d = {src_q[23:0], b};
			if (pos == tcp4 + TCP_PORT_HI) v4_port_d[15:8] = b;
			if (pos == tcp4 + TCP_PORT_LO) v4_port_d[7:0] = b;
			if (pos == tcp4 + TCP_FLAGS) flags_d = b;
			if (pos == TCP6_BASE + TCP_PORT_HI) v6_port_d[15:8] = b;
			if (pos == TCP6_BASE + TCP_PORT_LO) v6_port_d[7:0] = b;
		end
	end

	// frame length saturates with the offset
	assign len  = cap ? ({1'b0, pos} + 8'd1) : {1'b0, OFFSET_MAX};
	assign ihl4 = {ver_ihl_d[3:0], 2'b00};

	// verdict rules, ipv6 first
	assign v6_hit = (len >= MIN_LEN_V6) && (etype_d == ETYPE_IPV6) &&
		(ver_ihl_d[7:4] == IP_VER6) && (v6_next_d == PROTO_TCP) && (v6_port_d == port);
	assign v4_hit = (len >= MIN_LEN_V4) && (etype_d == ETYPE_IPV4) &&
		(ver_ihl_d[7:4] == IP_VER4) && (ihl4 >= IP4_MIN_LEN) &&
		(len >= ETH_TCP_LEN + {2'b00, ihl4}) && (proto_d == PROTO_TCP) &&
		((frag_d & FRAG_MASK) == 16'h0000) && (v4_port_d == port) &&
		flags_d[FLAG_SYN_BIT] && !flags_d[FLAG_ACK_BIT];

	assign count_d = count_q + 32'd1;

	// result item for a closing byte
	always_comb begin
		result.frames_seen    = count_d;
		result.source_address = 32'h0;
		if (v6_hit) begin
			result.verdict = VERDICT_REFUSE;
		end else if (v4_hit) begin
			result.verdict        = VERDICT_GATE;
			result.source_address = src_d;
		end else begin
			result.verdict = VERDICT_PASS;
		end
	end

	// header state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			etype_q   <= '0;
			ver_ihl_q <= '0;
			frag_q    <= '0;
			proto_q   <= '0;
			v6_next_q <= '0;
			src_q     <= '0;
			v4_port_q <= '0;
			v6_port_q <= '0;
			flags_q   <= '0;
			count_q   <= '0;
		end else if (step) begin
			etype_q   <= etype_d;
			ver_ihl_q <= ver_ihl_d;
			frag_q    <= frag_d;
			proto_q   <= proto_d;
			v6_next_q <= v6_next_d;
			src_q     <= src_d;
			v4_port_q <= v4_port_d;
			v6_port_q <= v6_port_d;
			flags_q   <= flags_d;
			if (item_s1.last_byte) begin
				offset_q <= '0;
				count_q  <= count_d;
			end else if (cap) begin
				offset_q <= offset_q + 7'd1;
			end
		end
	end

	// a frame starts over at offset zero
	a_offset_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.last_byte |=> offset_q == 7'd0)
		else $error("offset not cleared after frame end");

	// the count moves only at a frame end
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && item_s1.last_byte) |=> $stable(count_q))
		else $error("frame count changed mid frame");

	// the source address is shown only with a gate verdict
	a_src_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.verdict != VERDICT_GATE |-> result.source_address == 32'h0)
		else $error("source address leaked");

endmodule
`default_nettype wire

// ----- hw/rtl/sfc_out_stage.sv -----
// result register of the tcp syn frame classifier
`default_nettype none
module sfc_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire sfc_pkg::out_item_t result,
	output logic                    out_free,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sfc_pkg::out_item_t      out_item
);
	import sfc_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;
	assign out_free  = !valid_q || !out_stall;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_item <= result;
		end
	end

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ----- hw/rtl/tcp_syn_frame_classifier_unit.sv -----
// Ethernet frame classifier: one byte per cycle in unless stalled, one verdict per frame out
// A closing byte sits in the input register; its verdict then goes to the result register.
// Throughput: one byte per cycle unless in_stall; the two registers decouple the sides.
// A closing byte waits in the input register only while a stalled result is still held.
// Reset (arst_n low, asynchronous) empties both registers, clears all captured header
// fields and the frame count, and sets the protected port to 443.
`default_nettype none
module tcp_syn_frame_classifier_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sfc_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sfc_pkg::out_item_t      out_item,
	input  wire logic               cfg_wr_en,
	input  wire logic [15:0]        cfg_wr_data
);
	import sfc_pkg::*;

	logic       out_free;
	logic       step;
	in_item_t   item_s1;
	out_item_t  result;
	logic [15:0] port_q;

	// protected port register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= PORT_RESET;
		end else if (cfg_wr_en) begin
			port_q <= cfg_wr_data;
		end
	end

	sfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_free (out_free),
		.step     (step),
		.item_s1  (item_s1)
	);

	sfc_hdr_capture u_cap (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.port    (port_q),
		.result  (result)
	);

	sfc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && item_s1.last_byte),
		.result    (result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// the input side only waits behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// self-checking testbench of the tcp syn frame classifier unit
`default_nettype none
module tb;
	import sfc_pkg::*;

	localparam int FRAME_BUF = 140;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 600;
	localparam logic [7:0] FLAGS_SYN = 8'h01 << FLAG_SYN_BIT;
	localparam logic [7:0] FLAGS_SYN_ACK = FLAGS_SYN | (8'h01 << FLAG_ACK_BIT);
	localparam logic [15:0] FRAG_DF = 16'h4000;
	localparam logic [15:0] FRAG_MF = 16'h2000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	tcp_syn_frame_classifier_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// frame bytes waiting for the driver and verdicts waiting for the block
	in_item_t  frame_bytes[$];
	out_item_t verdict_queue[$];
	int        bytes_owed = 0;
	int        fail_count = 0;
	int        quiet_cycles = 0;
	logic      in_fire = 1'b0;
	int        send_gap = 0;
	int        stall_left = 0;
	bit        long_hold_req = 1'b0;
	bit        steady_tail = 1'b0;
	logic [7:0] frm [FRAME_BUF];

	// shadow copy of the classifier state
	logic [15:0] port_copy;
	logic [6:0]  byte_ofs;
	logic [15:0] etype_q;
	logic [7:0]  ver_ihl_q;
	logic [15:0] frag_q;
	logic [7:0]  proto_q;
	logic [7:0]  next_hdr_q;
	logic [31:0] src_q;
	logic [15:0] v4_port_q;
	logic [15:0] v6_port_q;
	logic [7:0]  flags_q;
	logic [31:0] frame_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// capture header fields of one byte and classify at the end of a frame
	task automatic classify_byte(input in_item_t it);
		logic [6:0] pos;
		logic [7:0] b;
		logic [7:0] tcp4;
		logic [7:0] ihl4;
		logic [7:0] len;
		logic       v6_hit;
		logic       v4_hit;
		out_item_t  res;
		pos = byte_ofs;
		b = it.data_byte;
		tcp4 = {1'b0, ETH_HDR_LEN} + {2'b00, ver_ihl_q[3:0], 2'b00};
		if (pos < OFFSET_MAX) begin
			if (pos == OFS_ETYPE_HI) etype_q[15:8] = b;
			if (pos == OFS_ETYPE_LO) etype_q[7:0] = b;
			if (pos == OFS_VER_IHL) ver_ihl_q = b;
			if (pos == OFS_FRAG_HI) begin
				frag_q[15:8] = b;
				next_hdr_q = b;
			end
			if (pos == OFS_FRAG_LO) frag_q[7:0] = b;
			if (pos == OFS_PROTO) proto_q = b;
			if (pos >= OFS_SRC_LO && pos <= OFS_SRC_HI) src_q = {src_q[23:0], b};
			if ({1'b0, pos} == tcp4 + {1'b0, TCP_PORT_HI}) v4_port_q[15:8] = b;
			if ({1'b0, pos} == tcp4 + {1'b0, TCP_PORT_LO}) v4_port_q[7:0] = b;
			if ({1'b0, pos} == tcp4 + {1'b0, TCP_FLAGS}) flags_q = b;
			if (pos == TCP6_BASE + TCP_PORT_HI) v6_port_q[15:8] = b;
			if (pos == TCP6_BASE + TCP_PORT_LO) v6_port_q[7:0] = b;
		end
		if (!it.last_byte) begin
			if (byte_ofs < OFFSET_MAX) byte_ofs = byte_ofs + 7'd1;
		end else begin
			len = {1'b0, pos} + 8'd1;
			if (len > {1'b0, OFFSET_MAX}) len = {1'b0, OFFSET_MAX};
			ihl4 = {2'b00, ver_ihl_q[3:0], 2'b00};
			frame_cnt = frame_cnt + 32'd1;
			v6_hit = len >= MIN_LEN_V6 && etype_q == ETYPE_IPV6 && ver_ihl_q[7:4] == IP_VER6
				&& next_hdr_q == PROTO_TCP && v6_port_q == port_copy;
			v4_hit = len >= MIN_LEN_V4 && etype_q == ETYPE_IPV4 && ver_ihl_q[7:4] == IP_VER4
				&& ihl4 >= {2'b00, IP4_MIN_LEN} && len >= ETH_TCP_LEN + ihl4
				&& proto_q == PROTO_TCP && (frag_q & FRAG_MASK) == 16'd0
				&& v4_port_q == port_copy && flags_q[FLAG_SYN_BIT] && !flags_q[FLAG_ACK_BIT];
			res.verdict = VERDICT_PASS;
			res.source_address = '0;
			res.frames_seen = frame_cnt;
			if (v6_hit) begin
				res.verdict = VERDICT_REFUSE;
			end else if (v4_hit) begin
				res.verdict = VERDICT_GATE;
				res.source_address = src_q;
			end
			verdict_queue.push_back(res);
			byte_ofs = '0;
		end
	endtask

	// monitor: predict on accepted bytes, check accepted verdicts
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
			port_copy = PORT_RESET;
			byte_ofs = '0;
			etype_q = '0;
			ver_ihl_q = '0;
			frag_q = '0;
			proto_q = '0;
			next_hdr_q = '0;
			src_q = '0;
			v4_port_q = '0;
			v6_port_q = '0;
			flags_q = '0;
			frame_cnt = '0;
			quiet_cycles = 0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (cfg_wr_en) port_copy = cfg_wr_data;
			if (in_valid && !in_stall) begin
				classify_byte(in_item);
				bytes_owed--;
			end
			if (out_valid && !out_stall) begin
				if (verdict_queue.size() == 0) begin
					$error("unexpected verdict item: verdict %0d frames_seen %0d",
						out_item.verdict, out_item.frames_seen);
					fail_count++;
				end else begin
					want = verdict_queue.pop_front();
					if (out_item.verdict !== want.verdict) begin
						$error("verdict: expected %0d, actual %0d", want.verdict, out_item.verdict);
						fail_count++;
					end
					if (out_item.source_address !== want.source_address) begin
						$error("source_address: expected %h, actual %h",
							want.source_address, out_item.source_address);
						fail_count++;
					end
					if (out_item.frames_seen !== want.frames_seen) begin
						$error("frames_seen: expected %0d, actual %0d",
							want.frames_seen, out_item.frames_seen);
						fail_count++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// driver: offer the next byte once the current one is taken, with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_gap == 0 && !steady_tail && $urandom_range(0, 19) == 0)
				send_gap = $urandom_range(1, 16);
			if (send_gap > 0 || frame_bytes.size() == 0) begin
				if (send_gap > 0) send_gap--;
				in_valid <= 1'b0;
			end else begin
				in_item <= frame_bytes.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (long_hold_req) begin
				stall_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (stall_left == 0 && !steady_tail && $urandom_range(0, 14) == 0)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic wait_drained();
		while (bytes_owed != 0 || verdict_queue.size() != 0) @(negedge clk);
	endtask

	task automatic write_port(input logic [15:0] value);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic fill_random();
		for (int i = 0; i < FRAME_BUF; i++) frm[i] = 8'($urandom);
	endtask

	task automatic shape_ipv4(input logic [3:0] ihl, input logic [15:0] dport,
		input logic [7:0] flags, input logic [15:0] frag);
		int tcp;
		tcp = ETH_HDR_LEN + 4 * ihl;
		frm[OFS_ETYPE_HI] = ETYPE_IPV4[15:8];
		frm[OFS_ETYPE_LO] = ETYPE_IPV4[7:0];
		frm[OFS_VER_IHL] = {IP_VER4, ihl};
		frm[OFS_FRAG_HI] = frag[15:8];
		frm[OFS_FRAG_LO] = frag[7:0];
		frm[OFS_PROTO] = PROTO_TCP;
		frm[tcp + TCP_PORT_HI] = dport[15:8];
		frm[tcp + TCP_PORT_LO] = dport[7:0];
		frm[tcp + TCP_FLAGS] = flags;
	endtask

	task automatic shape_ipv6(input logic [15:0] dport, input logic [7:0] next_hdr);
		frm[OFS_ETYPE_HI] = ETYPE_IPV6[15:8];
		frm[OFS_ETYPE_LO] = ETYPE_IPV6[7:0];
		frm[OFS_VER_IHL] = {IP_VER6, 4'($urandom)};
		frm[OFS_FRAG_HI] = next_hdr;
		frm[TCP6_BASE + TCP_PORT_HI] = dport[15:8];
		frm[TCP6_BASE + TCP_PORT_LO] = dport[7:0];
	endtask

	task automatic send_frame(input int len);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data_byte = frm[i];
			it.last_byte = (i == len - 1);
			frame_bytes.push_back(it);
			bytes_owed++;
		end
	endtask

	task automatic dir_v4(input int len, input logic [3:0] ihl, input logic [15:0] dport,
		input logic [7:0] flags, input logic [15:0] frag);
		fill_random();
		shape_ipv4(ihl, dport, flags, frag);
		send_frame(len);
	endtask

	task automatic dir_v6(input int len, input logic [15:0] dport, input logic [7:0] next_hdr);
		fill_random();
		shape_ipv6(dport, next_hdr);
		send_frame(len);
	endtask

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 3) != 0) return port_copy;
		return 16'($urandom);
	endfunction

	// mostly well-formed headers with random content, some broken, some noise
	task automatic random_frame(output int len);
		int kind;
		int need;
		logic [3:0] ihl;
		logic [7:0] flags;
		logic [15:0] frag;
		kind = $urandom_range(0, 9);
		fill_random();
		if (kind <= 4) begin
			ihl = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
			flags = 8'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				flags[FLAG_SYN_BIT] = 1'b1;
				flags[FLAG_ACK_BIT] = 1'b0;
			end
			frag = ($urandom_range(0, 3) != 0) ? {1'b0, 1'($urandom), 14'd0} : 16'($urandom);
			shape_ipv4(ihl, pick_port(), flags, frag);
			if ($urandom_range(0, 7) == 0) frm[$urandom_range(12, 27 + 4 * ihl)] = 8'($urandom);
			need = ETH_TCP_LEN + 4 * ihl;
		end else if (kind <= 7) begin
			shape_ipv6(pick_port(), ($urandom_range(0, 3) != 0) ? PROTO_TCP : 8'($urandom));
			if ($urandom_range(0, 7) == 0) frm[$urandom_range(12, 20)] = 8'($urandom);
			need = MIN_LEN_V6;
		end else begin
			need = $urandom_range(1, 90);
		end
		case ($urandom_range(0, 5))
			0: len = (need > 1) ? need - 1 : 1;
			1: len = $urandom_range(1, 40);
			2: len = $urandom_range(120, FRAME_BUF);
			default: len = need + $urandom_range(0, 24);
		endcase
		if (len > FRAME_BUF) len = FRAME_BUF;
		send_frame(len);
	endtask

	task automatic random_phase(input bit long_hold, input bit pause_midway);
		int items;
		int frames;
		int len;
		items = 0;
		frames = 0;
		while (items < 40 || frames < 2) begin
			random_frame(len);
			items += len;
			frames++;
			// receiver holds off while the sender keeps offering bytes
			if (long_hold && frames == 1) long_hold_req = 1'b1;
			// sender waits for every verdict before going on
			if (pause_midway && frames == 1) wait_drained();
		end
		wait_drained();
	endtask

	// stimulus and end of run
	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at the reset port
		dir_v4(54, 4'd5, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v4(53, 4'd5, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v4(60, 4'd5, PORT_RESET, FLAGS_SYN_ACK, 16'd0);
		dir_v4(60, 4'd5, PORT_RESET, FLAGS_SYN, FRAG_DF);
		dir_v4(60, 4'd5, PORT_RESET, FLAGS_SYN, FRAG_MF);
		dir_v4(60, 4'd5, PORT_RESET, FLAGS_SYN, 16'd1);
		dir_v4(94, 4'd15, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v4(93, 4'd15, PORT_RESET, FLAGS_SYN, 16'd0);
		// bogus ihl values
		dir_v4(60, 4'd3, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v4(60, 4'd0, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v4(60, 4'd5, PORT_RESET + 16'd1, FLAGS_SYN, 16'd0);
		dir_v6(74, PORT_RESET, PROTO_TCP);
		dir_v6(73, PORT_RESET, PROTO_TCP);
		dir_v6(80, PORT_RESET, 8'd17);
		dir_v6(80, PORT_RESET - 16'd1, PROTO_TCP);
		// long frames saturate the byte counter
		dir_v4(FRAME_BUF, 4'd5, PORT_RESET, FLAGS_SYN, 16'd0);
		dir_v6(FRAME_BUF, PORT_RESET, PROTO_TCP);
		// short frame after a hit keeps stale fields but must pass
		fill_random();
		send_frame(20);
		send_frame(1);
		for (int i = 0; i < FRAME_BUF; i++) frm[i] = 8'h00;
		send_frame(64);
		for (int i = 0; i < FRAME_BUF; i++) frm[i] = 8'hFF;
		send_frame(64);

		// port zero and the top port
		write_port(16'd0);
		dir_v4(60, 4'd5, 16'd0, FLAGS_SYN, 16'd0);
		dir_v6(80, 16'd0, PROTO_TCP);
		write_port(16'hFFFF);
		dir_v4(60, 4'd5, 16'hFFFF, FLAGS_SYN, 16'd0);
		dir_v6(80, 16'hFFFF, PROTO_TCP);

		// random phases across port settings
		write_port(16'($urandom_range(1, 65535)));
		random_phase(1'b0, 1'b0);
		write_port(16'd1);
		random_phase(1'b1, 1'b0);
		write_port(16'hFFFF);
		random_phase(1'b0, 1'b1);
		write_port(16'd0);
		random_phase(1'b0, 1'b0);
		write_port(PORT_RESET);
		steady_tail = 1'b1;
		random_phase(1'b0, 1'b0);

		wait_drained();
		repeat (8) @(negedge clk);
		if (verdict_queue.size() != 0) begin
			$error("%0d verdict items never arrived", verdict_queue.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
